/* hw/rtl/pvti_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pvti_pkg
// Shared types and constants of the PVT table interpolator.
// ----------------------------------------------------------------------------
package pvti_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int ENTRY_W    = 6;
    localparam int CFG_W      = 7;
    localparam int DCNT_W     = $clog2(VALUE_BITS) + 1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] p;
        logic [VALUE_BITS-1:0] vf;
        logic [VALUE_BITS-1:0] sw;
        logic [VALUE_BITS-1:0] vs;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/pvt_table_linear_interpolator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pvt_table_linear_interpolator_top
// Piecewise-linear breakpoint table with interpolated property lookup.
// ----------------------------------------------------------------------------
// Breakpoints live in a ring of 64 cells. A write item loads one cell and its
// all-zero result is registered in ST_DONE once the output register is free.
// A query item rotates the ring once past the search head, loads three serial
// dividers, runs them in parallel at one bit per cycle and registers the result
// in ST_DONE once the output register is free. A new item is taken only in
// ST_IDLE, at the earliest in the cycle after the result of the last one is
// registered; a result may wait in ST_DONE for out_ready. One result may wait
// in the output register while the next item is taken.
module pvt_table_linear_interpolator_top
    import pvti_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  func,
    input  wire logic [ENTRY_W-1:0]    entry_index,
    input  wire logic [VALUE_BITS-1:0] pressure_in,
    input  wire logic [VALUE_BITS-1:0] volume_factor_in,
    input  wire logic [VALUE_BITS-1:0] specific_weight_in,
    input  wire logic [VALUE_BITS-1:0] viscosity_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [VALUE_BITS-1:0] volume_factor_out,
    output logic      [VALUE_BITS-1:0] specific_weight_out,
    output logic      [VALUE_BITS-1:0] viscosity_out,
    output logic                       out_of_range,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]      cfg_reg;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [VALUE_BITS-1:0] p_reg;
    entry_t                prev_reg, lo_reg, hi_reg;
    logic                  hit_reg, oor_reg, wr_item_reg;
    logic [VALUE_BITS-1:0] off_reg;

    logic                  in_acc, shift, div_load, div_step, out_load;
    entry_t                ring [MAX_POINTS];
    entry_t                head, wr_data;
    logic [31:0]           n_eff;
    logic [IDX_W-1:0]      last_idx;
    logic [VALUE_BITS-1:0] den_w, off_w;
    logic [VALUE_BITS-1:0] a_vf, a_sw, a_vs, q_vf, q_sw, q_vs;
    logic [VALUE_BITS-1:0] r_vf, r_sw, r_vs;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign shift     = (state_reg == ST_SCAN);
    assign head      = ring[0];
    assign wr_data   = '{p: pressure_in, vf: volume_factor_in,
                         sw: specific_weight_in, vs: viscosity_in};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            pvti_cell u_cell (
                .clk     (clk),
                .shift   (shift),
                .wr_en   (in_acc && (func == FUNC_WRITE) && (32'(entry_index) == 32'(gi))),
                .wr_data (wr_data),
                .nb_data (ring[(gi + 1) % MAX_POINTS]),
                .data    (ring[gi])
            );
        end
    endgenerate

    always_comb
    begin
        if (cfg_reg < CFG_W'(2))
        begin
            n_eff = 32'd2;
        end
        else if (32'(cfg_reg) > 32'(MAX_POINTS))
        begin
            n_eff = 32'(MAX_POINTS);
        end
        else
        begin
            n_eff = 32'(cfg_reg);
        end
        last_idx = IDX_W'(n_eff - 32'd1);
    end

    // segment span and offset, taken once the scan is complete
    always_comb
    begin
        den_w = (hi_reg.p >= lo_reg.p) ? (hi_reg.p - lo_reg.p) : '0;
        off_w = (den_w == '0) ? '0 : (p_reg - lo_reg.p);
        a_vf  = (hi_reg.vf >= lo_reg.vf) ? (hi_reg.vf - lo_reg.vf) : (lo_reg.vf - hi_reg.vf);
        a_sw  = (hi_reg.sw >= lo_reg.sw) ? (hi_reg.sw - lo_reg.sw) : (lo_reg.sw - hi_reg.sw);
        a_vs  = (hi_reg.vs >= lo_reg.vs) ? (hi_reg.vs - lo_reg.vs) : (lo_reg.vs - hi_reg.vs);
    end

    pvti_div u_div_vf (.clk(clk), .load(div_load), .step(div_step),
                       .a(a_vf), .off(off_w), .den(den_w), .q(q_vf));
    pvti_div u_div_sw (.clk(clk), .load(div_load), .step(div_step),
                       .a(a_sw), .off(off_w), .den(den_w), .q(q_sw));
    pvti_div u_div_vs (.clk(clk), .load(div_load), .step(div_step),
                       .a(a_vs), .off(off_w), .den(den_w), .q(q_vs));

    always_comb
    begin
        if (off_reg == '0)
        begin
            r_vf = lo_reg.vf;
            r_sw = lo_reg.sw;
            r_vs = lo_reg.vs;
        end
        else
        begin
            r_vf = (hi_reg.vf >= lo_reg.vf) ? (lo_reg.vf + q_vf) : (lo_reg.vf - q_vf);
            r_sw = (hi_reg.sw >= lo_reg.sw) ? (lo_reg.sw + q_sw) : (lo_reg.sw - q_sw);
            r_vs = (hi_reg.vs >= lo_reg.vs) ? (lo_reg.vs + q_vs) : (lo_reg.vs - q_vs);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dcnt_next  = dcnt_reg;
        div_load   = 1'b0;
        div_step   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                begin
                    state_next = (func == FUNC_QUERY) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(MAX_POINTS - 1))
                begin
                    state_next = ST_DIV;
                    dcnt_next  = '0;
                end
            end
            ST_DIV:
            begin
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == '0)
                begin
                    div_load = 1'b1;
                end
                else
                begin
                    div_step = 1'b1;
                end
                if (dcnt_reg == DCNT_W'(VALUE_BITS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg   <= CFG_W'(2);
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dcnt_reg  <= dcnt_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // search head: sees entry cnt_reg of the table while the ring rotates
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg       <= pressure_in;
            wr_item_reg <= (func == FUNC_WRITE);
            hit_reg     <= 1'b0;
            oor_reg     <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            prev_reg <= head;
            if (cnt_reg == '0)
            begin
                if (p_reg < head.p)
                begin
                    oor_reg <= 1'b1;
                end
                else if (p_reg == head.p)
                begin
                    hit_reg <= 1'b1;
                    lo_reg  <= head;
                    hi_reg  <= head;
                end
            end
            else if (cnt_reg <= last_idx)
            begin
                if (!hit_reg && (p_reg <= head.p || cnt_reg == last_idx))
                begin
                    hit_reg <= 1'b1;
                    lo_reg  <= prev_reg;
                    hi_reg  <= head;
                end
                if (cnt_reg == last_idx && p_reg > head.p)
                begin
                    oor_reg <= 1'b1;
                end
            end
        end
        if (div_load)
        begin
            off_reg <= off_w;
        end
        if (out_load)
        begin
            if (wr_item_reg || oor_reg)
            begin
                volume_factor_out   <= '0;
                specific_weight_out <= '0;
                viscosity_out       <= '0;
            end
            else
            begin
                volume_factor_out   <= r_vf;
                specific_weight_out <= r_sw;
                viscosity_out       <= r_vs;
            end
            out_of_range <= !wr_item_reg && oor_reg;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pvti_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pvti_cell
// One breakpoint of the table ring; loads a write or takes its neighbor's entry.
// ----------------------------------------------------------------------------
module pvti_cell
    import pvti_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   shift,
    input  wire logic   wr_en,
    input  wire entry_t wr_data,
    input  wire entry_t nb_data,
    output entry_t      data
);

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_reg <= wr_data;
        end
        else if (shift)
        begin
            data_reg <= nb_data;
        end
    end

    assign data = data_reg;

endmodule
`default_nettype wire

/* hw/rtl/pvti_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pvti_div
// Serial scaled quotient floor(a * off / den), one bit of a per step.
// ----------------------------------------------------------------------------
module pvti_div
    import pvti_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire logic                  step,
    input  wire logic [VALUE_BITS-1:0] a,
    input  wire logic [VALUE_BITS-1:0] off,
    input  wire logic [VALUE_BITS-1:0] den,
    output logic      [VALUE_BITS-1:0] q
);

    logic [VALUE_BITS-1:0] a_reg, off_reg, den_reg, q_reg, q_next;
    logic [VALUE_BITS:0]   r_reg, r_next;
    logic [VALUE_BITS:0]   r1, r2;
    logic                  c1, c2;

    always_comb
    begin
        r1 = {r_reg[VALUE_BITS-1:0], 1'b0};
        c1 = (r1 >= {1'b0, den_reg});
        if (c1)
        begin
            r1 = r1 - {1'b0, den_reg};
        end
        r2 = r1;
        c2 = 1'b0;
        if (a_reg[VALUE_BITS-1])
        begin
            r2 = r1 + {1'b0, off_reg};
            c2 = (r2 >= {1'b0, den_reg});
            if (c2)
            begin
                r2 = r2 - {1'b0, den_reg};
            end
        end
        r_next = r2;
        q_next = {q_reg[VALUE_BITS-2:0], 1'b0} + VALUE_BITS'(c1) + VALUE_BITS'(c2);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg   <= a;
            off_reg <= off;
            den_reg <= den;
            q_reg   <= '0;
            r_reg   <= '0;
        end
        else if (step)
        begin
            a_reg <= {a_reg[VALUE_BITS-2:0], 1'b0};
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

/* tb/pvt_interp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_interp_checker
// Tracks the breakpoint table and count register seen on the input and
// configuration channels. It predicts each query by piecewise-linear
// interpolation, a write as all zeros; compares each accepted result by field.
// ----------------------------------------------------------------------------
module pvt_interp_checker
    import pvti_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic                  func,
    input  wire logic [ENTRY_W-1:0]    entry_index,
    input  wire logic [VALUE_BITS-1:0] pressure_in,
    input  wire logic [VALUE_BITS-1:0] volume_factor_in,
    input  wire logic [VALUE_BITS-1:0] specific_weight_in,
    input  wire logic [VALUE_BITS-1:0] viscosity_in,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [VALUE_BITS-1:0] volume_factor_out,
    input  wire logic [VALUE_BITS-1:0] specific_weight_out,
    input  wire logic [VALUE_BITS-1:0] viscosity_out,
    input  wire logic                  out_of_range,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output int                         fail_count,
    output int                         pending_count,
    output int                         query_count,
    output int                         oor_count
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] vf;
        logic [VALUE_BITS-1:0] sw;
        logic [VALUE_BITS-1:0] vs;
        logic                  oor;
    } lookup_t;

    entry_t          bp_table [MAX_POINTS];
    logic [CFG_W-1:0] point_count;
    lookup_t         lookup_queue [$];

    function automatic logic [VALUE_BITS-1:0] scale_span(
        logic [VALUE_BITS-1:0] span, logic [VALUE_BITS-1:0] off,
        logic [VALUE_BITS-1:0] den);
        logic [2*VALUE_BITS-1:0] prod;
        prod = span * off;
        prod = prod / den;
        return prod[VALUE_BITS-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] blend(
        logic [VALUE_BITS-1:0] lo, logic [VALUE_BITS-1:0] hi,
        logic [VALUE_BITS-1:0] off, logic [VALUE_BITS-1:0] den);
        if (off == 0)
            return lo;
        if (hi >= lo)
            return lo + scale_span(hi - lo, off, den);
        return lo - scale_span(lo - hi, off, den);
    endfunction

    function automatic lookup_t lookup_pressure(logic [VALUE_BITS-1:0] p);
        lookup_t r;
        int n;
        int f;
        int k;
        logic [VALUE_BITS-1:0] off;
        logic [VALUE_BITS-1:0] den;
        r = '0;
        n = point_count;
        if (n < 2)
            n = 2;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        if (p < bp_table[0].p || p > bp_table[n-1].p)
        begin
            r.oor = 1'b1;
            return r;
        end
        f = 0;
        while (f < n - 1 && p > bp_table[f].p)
            f++;
        k = (f == 0) ? 0 : f - 1;
        off = p - bp_table[k].p;
        den = (bp_table[k+1].p >= bp_table[k].p) ? bp_table[k+1].p - bp_table[k].p : '0;
        if (den == 0)
            off = '0;
        r.vf = blend(bp_table[k].vf, bp_table[k+1].vf, off, den);
        r.sw = blend(bp_table[k].sw, bp_table[k+1].sw, off, den);
        r.vs = blend(bp_table[k].vs, bp_table[k+1].vs, off, den);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t e;
        lookup_t got;
        if (!rst_n)
        begin
            point_count   <= 7'd2;
            fail_count    <= 0;
            pending_count <= 0;
            query_count   <= 0;
            oor_count     <= 0;
            lookup_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                point_count <= cfg_data;
            if (in_valid && in_ready)
            begin
                if (func == FUNC_WRITE)
                begin
                    bp_table[entry_index] = '{pressure_in, volume_factor_in,
                                              specific_weight_in, viscosity_in};
                    lookup_queue.push_back('0);
                end
                else
                begin
                    e = lookup_pressure(pressure_in);
                    query_count <= query_count + 1;
                    if (e.oor)
                        oor_count <= oor_count + 1;
                    lookup_queue.push_back(e);
                end
            end
            if (out_valid && out_ready)
            begin
                got = '{volume_factor_out, specific_weight_out, viscosity_out, out_of_range};
                if (lookup_queue.size() == 0)
                begin
                    $error("result with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = lookup_queue.pop_front();
                    if (got !== e)
                    begin
                        if (got.vf !== e.vf)
                            $error("volume_factor_out exp %h got %h", e.vf, got.vf);
                        if (got.sw !== e.sw)
                            $error("specific_weight_out exp %h got %h", e.sw, got.sw);
                        if (got.vs !== e.vs)
                            $error("viscosity_out exp %h got %h", e.vs, got.vs);
                        if (got.oor !== e.oor)
                            $error("out_of_range exp %b got %b", e.oor, got.oor);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= lookup_queue.size();
        end
    end

endmodule

/* tb/tb_pvt_table_linear_interpolator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pvt_table_linear_interpolator_top
// Loads ascending breakpoint tables and queries them at random pressures,
// exact breakpoints and outside the range, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_pvt_table_linear_interpolator_top
    import pvti_pkg::*;
;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = FUNC_WRITE;
    logic [ENTRY_W-1:0]    entry_index = '0;
    logic [VALUE_BITS-1:0] pressure_in = '0;
    logic [VALUE_BITS-1:0] volume_factor_in = '0;
    logic [VALUE_BITS-1:0] specific_weight_in = '0;
    logic [VALUE_BITS-1:0] viscosity_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [VALUE_BITS-1:0] volume_factor_out;
    logic [VALUE_BITS-1:0] specific_weight_out;
    logic [VALUE_BITS-1:0] viscosity_out;
    logic                  out_of_range;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;
    int                    fail_count;
    int                    pending_count;
    int                    query_count;
    int                    oor_count;
    logic [VALUE_BITS-1:0] bp_p [MAX_POINTS];
    int                    n_used;
    int                    item_total = 0;
    bit                    hold_off = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pvt_table_linear_interpolator_top u_dut (.*);

    pvt_interp_checker u_chk (.*);

    // receiver: own stall pattern, plus a long hold-off on request
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                mode = $urandom_range(0, 2);
            if (hold_off)
                out_ready <= 1'b0;
            else if (mode == 0)
                out_ready <= 1'b1;
            else if (mode == 1)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_item(logic f, logic [ENTRY_W-1:0] idx, logic [VALUE_BITS-1:0] p,
                             logic [VALUE_BITS-1:0] vf, logic [VALUE_BITS-1:0] sw,
                             logic [VALUE_BITS-1:0] vs);
        in_valid           <= 1'b1;
        func               <= f;
        entry_index        <= idx;
        pressure_in        <= p;
        volume_factor_in   <= vf;
        specific_weight_in <= sw;
        viscosity_in       <= vs;
        do
            @(posedge clk);
        while (!in_ready);
        item_total++;
        if ($urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || out_valid)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_query(logic [VALUE_BITS-1:0] p);
        send_item(FUNC_QUERY, ENTRY_W'($urandom), p, $urandom, $urandom, $urandom);
    endtask

    // load entries 0..MAX_POINTS-1 ascending; mode 2 gives full-scale extremes
    task automatic load_table(int mode);
        logic [VALUE_BITS-1:0] p;
        logic [VALUE_BITS-1:0] step;
        p = (mode == 2) ? '0 : $urandom_range(0, 32'h0100_0000);
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            bp_p[i] = p;
            if (mode == 2)
                send_item(FUNC_WRITE, ENTRY_W'(i), p, (i % 2) ? '1 : '0, (i % 2) ? '0 : '1,
                          $urandom);
            else
                send_item(FUNC_WRITE, ENTRY_W'(i), p, $urandom, $urandom, $urandom);
            step = (mode == 2) ? 32'h03FF_FFFF : $urandom_range(1, (mode == 1) ? 3 : 32'h0100_0000);
            if (i == MAX_POINTS - 2 && mode == 2)
                p = '1;
            else
                p = p + step;
        end
    endtask

    task automatic random_query;
        int r;
        int k;
        r = $urandom_range(0, 9);
        k = $urandom_range(0, n_used - 2);
        if (r == 0)
            send_query(bp_p[$urandom_range(0, n_used - 1)]);
        else if (r == 1)
            send_query((bp_p[0] == 0) ? $urandom : $urandom_range(0, bp_p[0] - 1));
        else if (r == 2 && bp_p[n_used-1] != '1)
            send_query($urandom_range(bp_p[n_used-1] + 1, 32'hFFFF_FFFF));
        else
            send_query($urandom_range(bp_p[k], bp_p[k+1]));
    endtask

    initial
    begin
        int counts [6];
        counts = '{2, 64, 127, 17, 0, 5};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale table, default count, directed corners
        load_table(2);
        n_used = 2;
        send_query(bp_p[0]);
        send_query(bp_p[1]);
        send_query(bp_p[1] + 1);
        send_query(bp_p[0] + 1);
        send_query(bp_p[1] - 1);
        send_item(FUNC_WRITE, 6'd63, '1, '1, '1, '1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_count(CFG_W'(counts[ph]));
            n_used = (counts[ph] < 2) ? 2 : (counts[ph] > MAX_POINTS) ? MAX_POINTS : counts[ph];
            if (ph == 1)
            begin
                send_query('0);
                send_query('1);
                send_query(bp_p[MAX_POINTS-2]);
                send_query(32'hFFFF_FFFE);
            end
            if (ph > 1)
                load_table(ph % 2);
            if (ph == 3)
            begin
                hold_off = 1'b1;
                fork
                    repeat (40) random_query();
                    begin
                        repeat (600) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join
            end
            while (item_total < 150 + ph * 300)
                random_query();
            drain();
        end

        $display("Covered %0d items, %0d queries (%0d out of range), counts 0..127.",
                 item_total, query_count, oor_count);
        if (fail_count == 0)
            $display("** pvt_table_linear_interpolator_top: PASSED **");
        else
            $display("** pvt_table_linear_interpolator_top: FAILED **");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("** pvt_table_linear_interpolator_top: FAILED **");
        $finish;
    end

endmodule

/* pvt_table_linear_interpolator_top.f */
hw/rtl/pvti_pkg.sv
hw/rtl/pvti_cell.sv
hw/rtl/pvti_div.sv
hw/rtl/pvt_table_linear_interpolator_top.sv
tb/pvt_interp_checker.sv
tb/tb_pvt_table_linear_interpolator_top.sv
